// ===== hdl/rof_pkg.sv =====
// rof_pkg: shared constants, command encoding and interface structs for the
// overwriting ring FIFO. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rof_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = 7;
    localparam int FUNC_W     = 2;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_POP   = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        OP_PUSH  = 4'b0001,
        OP_POP   = 4'b0010,
        OP_CLEAR = 4'b0100,
        OP_NOP   = 4'b1000
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [DATA_WIDTH-1:0] data;
        logic [CNT_W-1:0]      count;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic head_valid;
    } q_stat_t;

endpackage

`default_nettype wire

// ===== hdl/rof_front.sv =====
// rof_front: accepts transactions on the command port and classifies the
// function code into a queued command. Depends on rof_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rof_front
    import rof_pkg::*;
(
    input  wire logic                  start,
    input  wire logic [FUNC_W-1:0]     func,
    input  wire logic [DATA_WIDTH-1:0] data_in,
    input  wire logic [CNT_W-1:0]      pop_count,
    input  wire q_stat_t               q_stat,
    output logic                       busy,
    output logic                       enq,
    output cmd_t                       enq_cmd
);

    always_comb
    begin
        busy          = q_stat.full;
        enq           = start & ~q_stat.full;
        enq_cmd.data  = data_in;
        enq_cmd.count = pop_count;
        case (func_t'(func))
            FUNC_PUSH:  enq_cmd.op = OP_PUSH;
            FUNC_POP:   enq_cmd.op = OP_POP;
            FUNC_CLEAR: enq_cmd.op = OP_CLEAR;
            default:    enq_cmd.op = OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/rof_cmd_queue.sv =====
// rof_cmd_queue: two-entry command queue between front and back ends.
// Depends on rof_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rof_cmd_queue
    import rof_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic enq,
    input  wire cmd_t enq_cmd,
    input  wire logic deq,
    output q_stat_t   q_stat,
    output cmd_t      head
);

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wptr_next = enq ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = deq ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg;
        if (enq && !deq)
            cnt_next = cnt_reg + 1'b1;
        else if (deq && !enq)
            cnt_next = cnt_reg - 1'b1;
        q_stat.full       = (cnt_reg == QCNT_W'(QDEPTH));
        q_stat.head_valid = (cnt_reg != '0);
        head              = entry_reg[rptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
            entry_reg[wptr_reg] <= enq_cmd;
    end

endmodule

`default_nettype wire

// ===== hdl/rof_back.sv =====
// rof_back: executes queued commands against the word store, owns the ring
// pointers, fill count, capacity register and result registers. Depends on rof_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rof_back
    import rof_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CNT_W-1:0]      cfg_wdata,
    input  wire q_stat_t               q_stat,
    input  wire cmd_t                  head,
    output logic                       deq,
    output logic                       done,
    output logic [DATA_WIDTH-1:0]      data_out,
    output logic                       status,
    output logic                       last,
    output logic                       is_full,
    output logic                       is_empty,
    output logic [CNT_W-1:0]           fill_level
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] wr_reg, wr_next;
    logic [ADDR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  cap_reg, cap_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;

    logic              res_valid_reg, res_valid_next;
    logic              res_mem_reg, res_mem_next;
    logic              res_status_reg, res_status_next;
    logic              res_last_reg, res_last_next;
    logic              res_full_reg, res_full_next;
    logic              res_empty_reg, res_empty_next;
    logic [CNT_W-1:0]  res_fill_reg, res_fill_next;

    logic              mem_we;
    logic              mem_re;
    logic              issue_word;
    logic              last_word;

    function automatic logic [ADDR_W-1:0] adv(input logic [ADDR_W-1:0] idx,
                                              input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] nxt;
        nxt = CNT_W'(idx) + 1'b1;
        return (nxt >= cap) ? '0 : nxt[ADDR_W-1:0];
    endfunction

    always_comb
    begin
        state_next      = state_reg;
        wr_next         = wr_reg;
        rd_next         = rd_reg;
        cnt_next        = cnt_reg;
        cap_next        = cap_reg;
        rem_next        = rem_reg;
        res_valid_next  = 1'b0;
        res_mem_next    = 1'b0;
        res_status_next = 1'b0;
        res_last_next   = 1'b1;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        deq             = 1'b0;
        issue_word      = 1'b0;
        last_word       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_stat.head_valid)
                begin
                    deq = 1'b1;
                    case (head.op)
                        OP_PUSH:
                        begin
                            mem_we         = 1'b1;
                            wr_next        = adv(wr_reg, cap_reg);
                            res_valid_next = 1'b1;
                            if (cnt_reg < cap_reg)
                                cnt_next = cnt_reg + 1'b1;
                            if (cnt_next == cap_reg)
                                rd_next = wr_next;
                        end
                        OP_POP:
                        begin
                            if (head.count == '0 || head.count > cnt_reg)
                            begin
                                res_valid_next  = 1'b1;
                                res_status_next = 1'b1;
                            end
                            else
                            begin
                                issue_word = 1'b1;
                                last_word  = (head.count == CNT_W'(1));
                                if (!last_word)
                                begin
                                    state_next = ST_RUN;
                                    rem_next   = head.count - 1'b1;
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            wr_next        = '0;
                            rd_next        = '0;
                            cnt_next       = '0;
                            res_valid_next = 1'b1;
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                issue_word = 1'b1;
                last_word  = (rem_reg == CNT_W'(1));
                rem_next   = rem_reg - 1'b1;
                if (last_word)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (issue_word)
        begin
            mem_re         = 1'b1;
            rd_next        = adv(rd_reg, cap_reg);
            cnt_next       = cnt_reg - 1'b1;
            res_valid_next = 1'b1;
            res_mem_next   = 1'b1;
            res_last_next  = last_word;
        end

        res_full_next  = (cnt_next == cap_reg);
        res_empty_next = (cnt_next == '0);
        res_fill_next  = cnt_next;

        // capacity write: saturate and flush the ring
        if (cfg_we)
        begin
            if (cfg_wdata == '0)
                cap_next = CNT_W'(1);
            else if (cfg_wdata > CNT_W'(DEPTH))
                cap_next = CNT_W'(DEPTH);
            else
                cap_next = cfg_wdata;
            wr_next  = '0;
            rd_next  = '0;
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_reg        <= '0;
            rd_reg        <= '0;
            cnt_reg       <= '0;
            cap_reg       <= CNT_W'(DEPTH);
            rem_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_reg        <= wr_next;
            rd_reg        <= rd_next;
            cnt_reg       <= cnt_next;
            cap_reg       <= cap_next;
            rem_reg       <= rem_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_mem_reg    <= res_mem_next;
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
        res_full_reg   <= res_full_next;
        res_empty_reg  <= res_empty_next;
        res_fill_reg   <= res_fill_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_reg] <= head.data;
        if (mem_re)
            rd_data_reg <= mem[rd_reg];
    end

    assign done       = res_valid_reg;
    assign data_out   = res_mem_reg ? rd_data_reg : '0;
    assign status     = res_status_reg;
    assign last       = res_last_reg;
    assign is_full    = res_full_reg;
    assign is_empty   = res_empty_reg;
    assign fill_level = res_fill_reg;

endmodule

`default_nettype wire

// ===== hdl/overwriting_ring_fifo.sv =====
// overwriting_ring_fifo: top level joining command front end, command queue
// and execution back end. Depends on rof_pkg, rof_front, rof_cmd_queue, rof_back.
`timescale 1ns / 1ps
`default_nettype none

// A transaction is taken when start is high and busy is low; busy rises only
// while the two-entry command queue is full. The back end retires one command
// per cycle except while a pop of several words runs: push, clear and refused
// or no-op commands give one result each, and a pop of n words gives n results,
// one per cycle, paced by the single read port of the word store. A result
// appears right after the edge at which its command leaves the queue; between
// a transaction's acceptance and its first result lie the queue register and
// the result registers. Each result is strobed by done for exactly one cycle;
// the receiver cannot hold them off, so it must take every strobed cycle.
// Writing cfg_wdata with cfg_we also empties the FIFO.
module overwriting_ring_fifo
    import rof_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CNT_W-1:0]      cfg_wdata,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [FUNC_W-1:0]     func,
    input  wire logic [DATA_WIDTH-1:0] data_in,
    input  wire logic [CNT_W-1:0]      pop_count,
    output logic                       done,
    output logic [DATA_WIDTH-1:0]      data_out,
    output logic                       status,
    output logic                       last,
    output logic                       is_full,
    output logic                       is_empty,
    output logic [CNT_W-1:0]           fill_level
);

    q_stat_t q_stat;
    logic    enq;
    logic    deq;
    cmd_t    enq_cmd;
    cmd_t    head;

    rof_front u_front (
        .start     (start),
        .func      (func),
        .data_in   (data_in),
        .pop_count (pop_count),
        .q_stat    (q_stat),
        .busy      (busy),
        .enq       (enq),
        .enq_cmd   (enq_cmd)
    );

    rof_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .enq     (enq),
        .enq_cmd (enq_cmd),
        .deq     (deq),
        .q_stat  (q_stat),
        .head    (head)
    );

    rof_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .q_stat     (q_stat),
        .head       (head),
        .deq        (deq),
        .done       (done),
        .data_out   (data_out),
        .status     (status),
        .last       (last),
        .is_full    (is_full),
        .is_empty   (is_empty),
        .fill_level (fill_level)
    );

endmodule

`default_nettype wire

// ===== verif/overwriting_ring_fifo_checker.sv =====
// overwriting_ring_fifo_checker: watches the command, config and result ports of
// overwriting_ring_fifo, predicts every result and compares it field by field.
// Depends on rof_pkg.
`timescale 1ns / 1ps

module overwriting_ring_fifo_checker
    import rof_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CNT_W-1:0]      cfg_wdata,
    input  wire logic                  start,
    input  wire logic                  busy,
    input  wire logic [FUNC_W-1:0]     func,
    input  wire logic [DATA_WIDTH-1:0] data_in,
    input  wire logic [CNT_W-1:0]      pop_count,
    input  wire logic                  done,
    input  wire logic [DATA_WIDTH-1:0] data_out,
    input  wire logic                  status,
    input  wire logic                  last,
    input  wire logic                  is_full,
    input  wire logic                  is_empty,
    input  wire logic [CNT_W-1:0]      fill_level,
    output int                         mismatches,
    output int                         outstanding,
    output int                         results_seen
);

    typedef struct packed {
        logic [DATA_WIDTH-1:0] data;
        logic                  status;
        logic                  last;
        logic                  full;
        logic                  empty;
        logic [CNT_W-1:0]      level;
    } fifo_result_t;

    logic [DATA_WIDTH-1:0] words [DEPTH];
    logic [ADDR_W-1:0]     wr_ptr;
    logic [ADDR_W-1:0]     rd_ptr;
    logic [CNT_W-1:0]      level;
    logic [CNT_W-1:0]      capacity;
    fifo_result_t          expected_q[$];
    int                    err_count = 0;
    int                    result_count = 0;

    function automatic logic [ADDR_W-1:0] ring_next(logic [ADDR_W-1:0] idx);
        int nxt;
        nxt = int'(idx) + 1;
        if (nxt >= int'(capacity))
            nxt = 0;
        return nxt[ADDR_W-1:0];
    endfunction

    task automatic queue_result(logic [DATA_WIDTH-1:0] d, logic st, logic lst);
        fifo_result_t r;
        r.data   = d;
        r.status = st;
        r.last   = lst;
        r.full   = (level == capacity);
        r.empty  = (level == 0);
        r.level  = level;
        expected_q.push_back(r);
    endtask

    task automatic predict_command(func_t f, logic [DATA_WIDTH-1:0] d, logic [CNT_W-1:0] n);
        case (f)
            FUNC_PUSH:
            begin
                words[wr_ptr] = d;
                wr_ptr = ring_next(wr_ptr);
                if (level < capacity)
                    level = level + 1'b1;
                if (level == capacity)
                    rd_ptr = wr_ptr;
                queue_result('0, 1'b0, 1'b1);
            end
            FUNC_POP:
            begin
                if (n == 0 || n > level)
                    queue_result('0, 1'b1, 1'b1);
                else
                begin
                    for (int k = 0; k < int'(n); k++)
                    begin
                        level = level - 1'b1;
                        queue_result(words[rd_ptr], 1'b0, (k + 1 == int'(n)));
                        rd_ptr = ring_next(rd_ptr);
                    end
                end
            end
            FUNC_CLEAR:
            begin
                wr_ptr = '0;
                rd_ptr = '0;
                level  = '0;
                queue_result('0, 1'b0, 1'b1);
            end
            default:
                queue_result('0, 1'b0, 1'b1);
        endcase
    endtask

    task automatic check_result();
        fifo_result_t want;
        result_count++;
        if (expected_q.size() == 0)
        begin
            $error("unexpected result: data_out %h status %0d last %0d",
                   data_out, status, last);
            err_count++;
            return;
        end
        want = expected_q.pop_front();
        if (data_out !== want.data)
        begin
            $error("data_out: expected %h, got %h", want.data, data_out);
            err_count++;
        end
        if (status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, status);
            err_count++;
        end
        if (last !== want.last)
        begin
            $error("last: expected %0d, got %0d", want.last, last);
            err_count++;
        end
        if (is_full !== want.full)
        begin
            $error("is_full: expected %0d, got %0d", want.full, is_full);
            err_count++;
        end
        if (is_empty !== want.empty)
        begin
            $error("is_empty: expected %0d, got %0d", want.empty, is_empty);
            err_count++;
        end
        if (fill_level !== want.level)
        begin
            $error("fill_level: expected %0d, got %0d", want.level, fill_level);
            err_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        logic [CNT_W-1:0] cap_v;
        if (!rst_n)
        begin
            wr_ptr   = '0;
            rd_ptr   = '0;
            level    = '0;
            capacity = CNT_W'(DEPTH);
            expected_q.delete();
        end
        else
        begin
            if (done)
                check_result();
            if (cfg_we)
            begin
                cap_v = cfg_wdata;
                if (cap_v == 0)
                    cap_v = CNT_W'(1);
                if (cap_v > DEPTH)
                    cap_v = CNT_W'(DEPTH);
                capacity = cap_v;
                wr_ptr   = '0;
                rd_ptr   = '0;
                level    = '0;
            end
            if (start && !busy)
                predict_command(func_t'(func), data_in, pop_count);
        end
        mismatches   <= err_count;
        outstanding  <= expected_q.size();
        results_seen <= result_count;
    end

endmodule

// ===== verif/overwriting_ring_fifo_tb.sv =====
// overwriting_ring_fifo_tb: drives directed and random push/pop/clear traffic
// across several capacity settings and gives the verdict.
// Depends on rof_pkg, overwriting_ring_fifo and overwriting_ring_fifo_checker.
`timescale 1ns / 1ps

module overwriting_ring_fifo_tb;
    import rof_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CNT_W-1:0]      cfg_wdata = '0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [FUNC_W-1:0]     func = FUNC_NOP;
    logic [DATA_WIDTH-1:0] data_in = '0;
    logic [CNT_W-1:0]      pop_count = '0;
    logic                  done;
    logic [DATA_WIDTH-1:0] data_out;
    logic                  status;
    logic                  last;
    logic                  is_full;
    logic                  is_empty;
    logic [CNT_W-1:0]      fill_level;
    int                    mismatches;
    int                    outstanding;
    int                    results_seen;

    int fifo_level;
    int fifo_cap;
    int commands_sent;
    int settings_used;
    bit steady;

    overwriting_ring_fifo dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .data_in    (data_in),
        .pop_count  (pop_count),
        .done       (done),
        .data_out   (data_out),
        .status     (status),
        .last       (last),
        .is_full    (is_full),
        .is_empty   (is_empty),
        .fill_level (fill_level)
    );

    overwriting_ring_fifo_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .data_in      (data_in),
        .pop_count    (pop_count),
        .done         (done),
        .data_out     (data_out),
        .status       (status),
        .last         (last),
        .is_full      (is_full),
        .is_empty     (is_empty),
        .fill_level   (fill_level),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("overwriting_ring_fifo_tb: done, errors");
        $finish;
    end

    // one transaction; start stays high on return so a back-to-back command
    // needs no extra edge
    task automatic send_command(func_t f, logic [DATA_WIDTH-1:0] d, logic [CNT_W-1:0] n);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        func      <= f;
        data_in   <= d;
        pop_count <= n;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        commands_sent++;
        case (f)
            FUNC_PUSH:  if (fifo_level < fifo_cap) fifo_level++;
            FUNC_POP:   if (n != 0 && int'(n) <= fifo_level) fifo_level -= int'(n);
            FUNC_CLEAR: fifo_level = 0;
            default:    ;
        endcase
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_capacity(logic [CNT_W-1:0] v);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        fifo_cap   = (v == 0) ? 1 : ((v > DEPTH) ? DEPTH : int'(v));
        fifo_level = 0;
        settings_used++;
    endtask

    task automatic random_command();
        int                    pick;
        logic [DATA_WIDTH-1:0] d;
        logic [CNT_W-1:0]      n;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0:       d = '0;
            1:       d = '1;
            default: d = $urandom;
        endcase
        n = CNT_W'($urandom_range(0, 127));
        if (pick < 50)
            send_command(FUNC_PUSH, d, n);
        else if (pick < 82)
        begin
            if (fifo_level > 0 && $urandom_range(0, 4) != 0)
                n = CNT_W'($urandom_range(1, fifo_level));
            send_command(FUNC_POP, d, n);
        end
        else if (pick < 92)
            send_command(FUNC_CLEAR, d, n);
        else
            send_command(FUNC_NOP, d, n);
    endtask

    initial
    begin
        logic [CNT_W-1:0] caps [8];
        fifo_level    = 0;
        fifo_cap      = DEPTH;
        commands_sent = 0;
        settings_used = 1;
        steady        = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // empty-FIFO refusals, no-op, field extremes, bad pop counts, clear
        send_command(FUNC_POP, '1, 7'd0);
        send_command(FUNC_POP, '0, 7'd1);
        send_command(FUNC_NOP, '1, 7'd127);
        send_command(FUNC_PUSH, '0, 7'd127);
        send_command(FUNC_PUSH, '1, 7'd0);
        send_command(FUNC_PUSH, 32'h1234_5678, 7'd64);
        send_command(FUNC_POP, '0, 7'd4);
        send_command(FUNC_POP, '0, 7'd127);
        send_command(FUNC_POP, '0, 7'd2);
        send_command(FUNC_POP, '0, 7'd1);
        send_command(FUNC_PUSH, 32'hA5A5_5A5A, 7'd0);
        send_command(FUNC_CLEAR, '1, 7'd1);
        send_command(FUNC_POP, '0, 7'd1);

        // overwrite of the oldest words once full
        set_capacity(7'd4);
        for (int i = 0; i < 6; i++)
            send_command(FUNC_PUSH, 32'hC0DE_0000 + i, 7'd0);
        send_command(FUNC_POP, '0, 7'd4);

        caps[0] = 7'd0;
        caps[1] = 7'd1;
        caps[2] = 7'd127;
        caps[3] = 7'd65;
        caps[4] = CNT_W'($urandom_range(2, 63));
        caps[5] = CNT_W'($urandom_range(2, 63));
        caps[6] = CNT_W'($urandom_range(2, 63));
        caps[7] = 7'd64;
        foreach (caps[p])
        begin
            set_capacity(caps[p]);
            steady = ($urandom_range(0, 3) == 0);
            // fill well past a full ring, then take it all in one run
            if (caps[p] == 7'd127)
            begin
                for (int i = 0; i < DEPTH + 2; i++)
                    send_command(FUNC_PUSH, $urandom, CNT_W'($urandom_range(0, 127)));
                send_command(FUNC_POP, $urandom, 7'd64);
            end
            for (int i = 0; i < 18; i++)
                random_command();
        end

        drain_results();
        repeat (12) @(posedge clk);
        $display("%0d commands over %0d capacity settings, %0d results checked",
                 commands_sent, settings_used, results_seen);
        if (mismatches == 0)
            $display("overwriting_ring_fifo_tb: done, clean");
        else
            $display("overwriting_ring_fifo_tb: done, errors");
        $finish;
    end

endmodule
